// ===== rtl/skyrp_pkg.sv =====
// Shared constants, types and codes for the skyline rectangle packer.
package skyrp_pkg;

  localparam int PAGE_WIDTH  = 256;
  localparam int PAGE_HEIGHT = 256;
  localparam int MAX_PAGES   = 1024;

  localparam int DIM_W  = 9;                              // block_width / block_height
  localparam int COL_W  = $clog2(PAGE_WIDTH + 1);         // column position 0..PAGE_WIDTH
  localparam int ADDR_W = $clog2(PAGE_WIDTH);             // column address
  localparam int HGT_W  = $clog2(PAGE_HEIGHT + 1);        // column height 0..PAGE_HEIGHT
  localparam int PG_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int ALU_W  = ((COL_W > HGT_W) ? COL_W : HGT_W) + 1;

  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [HGT_W-1:0]  hgt_t;
  typedef logic [PG_W-1:0]   page_t;
  typedef logic [ALU_W-1:0]  alu_t;
  typedef logic [9:0]        page_idx_t;
  typedef logic [7:0]        xpos_t;
  typedef logic [7:0]        ypos_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_TOO_LARGE,
    ST_FULL
  } status_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_OPEN,
    S_CUR,
    S_CUR_REV,
    S_SCAN,
    S_FIT,
    S_WRITE,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic  clear;
    logic  wr_en;
    addr_t wr_addr;
    hgt_t  wr_data;
    logic  rd_en;
    addr_t rd_addr;
  } colmem_req_t;

endpackage

// ===== rtl/skyrp_alu.sv =====
// Shared add/subtract unit with carry or borrow out.
module skyrp_alu (
  input  skyrp_pkg::alu_op_t op,
  input  skyrp_pkg::alu_t    a,
  input  skyrp_pkg::alu_t    b,
  output skyrp_pkg::alu_t    res,
  output logic               flag
);

  logic [skyrp_pkg::ALU_W:0] full;

  always_comb begin
    unique case (op)
      skyrp_pkg::ALU_ADD: full = {1'b0, a} + {1'b0, b};
      skyrp_pkg::ALU_SUB: full = {1'b0, a} - {1'b0, b};
      default:            full = '0;
    endcase
  end

  assign res  = full[skyrp_pkg::ALU_W-1:0];
  assign flag = full[skyrp_pkg::ALU_W];    // borrow on subtract

endmodule

// ===== rtl/skyrp_colmem.sv =====
// Column height memory with per-column valid bits, so that a page clear drops every column at once.
module skyrp_colmem (
  input  logic                   clk,
  input  logic                   rst,
  input  skyrp_pkg::colmem_req_t req,
  output skyrp_pkg::hgt_t        rd_data
);

  logic [skyrp_pkg::PAGE_WIDTH-1:0] vld;
  skyrp_pkg::hgt_t                  mem [skyrp_pkg::PAGE_WIDTH];
  skyrp_pkg::hgt_t                  data_q;
  logic                             vld_q;

  // a write in the clearing cycle still lands (reserved column)
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.clear) begin
      vld <= req.wr_en ? ({{(skyrp_pkg::PAGE_WIDTH-1){1'b0}}, 1'b1} << req.wr_addr) : '0;
    end else if (req.wr_en) begin
      vld[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
    if (req.rd_en) begin
      data_q <= mem[req.rd_addr];
      vld_q  <= vld[req.rd_addr];
    end
  end

  assign rd_data = vld_q ? data_q : '0;

endmodule

// ===== rtl/skyline_rect_packer.sv =====
// Top level: sequencer and datapath of the skyline rectangle packer.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid in_ready block_width        | into block
//          | block_height                         |
//  out     | out_valid out_ready page_index x_pos | out of block
//          | y_pos status                         |
//
// One item at a time. Each item is checked, then a column span is chosen at the
// sweep cursor (set flush right when it would pass the page edge), its columns
// are read from the height memory for the highest, the fit is tested and the
// columns are written; a failed fit opens a fresh page and tries again, or
// reports full on the last page. Oversized items go straight to the result.
// Reset is synchronous; it clears the page state at once via valid bits.
// The result waits in an output register; a stalled output holds the block
// only when the next result is ready to be written.
module skyline_rect_packer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [8:0] block_width,
  input  logic [8:0] block_height,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [9:0] page_index,
  output logic [7:0] x_pos,
  output logic [7:0] y_pos,
  output logic [1:0] status
);

  skyrp_pkg::state_t      state, state_next;
  skyrp_pkg::colmem_req_t mreq;
  skyrp_pkg::hgt_t        rd_data;

  skyrp_pkg::alu_op_t alu_op;
  skyrp_pkg::alu_t    alu_a, alu_b, alu_res;
  logic               alu_flag;

  // control state
  logic             opened;
  skyrp_pkg::page_t cur_page;
  skyrp_pkg::col_t  cursor, cursor_next;
  logic             reversed, reversed_next;
  logic             pend;
  skyrp_pkg::col_t  cnt;

  // payload
  skyrp_pkg::dim_t    w_q, h_q;
  skyrp_pkg::page_t   try_page;
  skyrp_pkg::col_t    x_q, x_next;
  skyrp_pkg::addr_t   addr;
  skyrp_pkg::hgt_t    y_q, ynew;
  skyrp_pkg::status_t code;

  logic too_large, over_edge, fit_fail, last_page, start_scan;

  skyrp_alu u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .res  (alu_res),
    .flag (alu_flag)
  );

  skyrp_colmem u_colmem (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq),
    .rd_data (rd_data)
  );

  assign too_large = (32'(w_q) > skyrp_pkg::PAGE_WIDTH) || (32'(h_q) > skyrp_pkg::PAGE_HEIGHT);
  assign over_edge = alu_res > skyrp_pkg::alu_t'(skyrp_pkg::PAGE_WIDTH);
  assign fit_fail  = alu_res > skyrp_pkg::alu_t'(skyrp_pkg::PAGE_HEIGHT);
  assign last_page = try_page == skyrp_pkg::page_t'(skyrp_pkg::MAX_PAGES - 1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      skyrp_pkg::S_IDLE:    if (in_valid) state_next = skyrp_pkg::S_CHECK;
      skyrp_pkg::S_CHECK: begin
        if (too_large)    state_next = skyrp_pkg::S_RESULT;
        else if (!opened) state_next = skyrp_pkg::S_OPEN;
        else              state_next = skyrp_pkg::S_CUR;
      end
      skyrp_pkg::S_OPEN:    state_next = skyrp_pkg::S_CUR;
      skyrp_pkg::S_CUR: begin
        if (!reversed && over_edge) state_next = skyrp_pkg::S_CUR_REV;
        else                        state_next = skyrp_pkg::S_SCAN;
      end
      skyrp_pkg::S_CUR_REV: state_next = skyrp_pkg::S_SCAN;
      skyrp_pkg::S_SCAN:    if (cnt == '0 && !pend) state_next = skyrp_pkg::S_FIT;
      skyrp_pkg::S_FIT: begin
        if (!fit_fail)      state_next = skyrp_pkg::S_WRITE;
        else if (last_page) state_next = skyrp_pkg::S_RESULT;
        else                state_next = skyrp_pkg::S_OPEN;
      end
      skyrp_pkg::S_WRITE:   if (cnt == '0) state_next = skyrp_pkg::S_RESULT;
      skyrp_pkg::S_RESULT:  if (!out_valid || out_ready) state_next = skyrp_pkg::S_IDLE;
      default:              state_next = skyrp_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake, shared unit operands, memory port
  always_comb begin
    in_ready = (state == skyrp_pkg::S_IDLE);

    alu_op = skyrp_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state)
      skyrp_pkg::S_CUR: begin
        alu_op = reversed ? skyrp_pkg::ALU_SUB : skyrp_pkg::ALU_ADD;
        alu_a  = skyrp_pkg::alu_t'(cursor);
        alu_b  = skyrp_pkg::alu_t'(w_q);
      end
      skyrp_pkg::S_CUR_REV: begin
        alu_op = skyrp_pkg::ALU_SUB;
        alu_a  = skyrp_pkg::alu_t'(skyrp_pkg::PAGE_WIDTH);
        alu_b  = skyrp_pkg::alu_t'(w_q);
      end
      skyrp_pkg::S_SCAN: begin
        alu_op = skyrp_pkg::ALU_SUB;    // borrow means the column is higher
        alu_a  = skyrp_pkg::alu_t'(y_q);
        alu_b  = skyrp_pkg::alu_t'(rd_data);
      end
      skyrp_pkg::S_FIT: begin
        alu_op = skyrp_pkg::ALU_ADD;
        alu_a  = skyrp_pkg::alu_t'(y_q);
        alu_b  = skyrp_pkg::alu_t'(h_q);
      end
      default: begin
        alu_op = skyrp_pkg::ALU_ADD;
      end
    endcase

    mreq.clear   = (state == skyrp_pkg::S_OPEN);
    mreq.wr_en   = ((state == skyrp_pkg::S_OPEN) && !opened) ||
                   ((state == skyrp_pkg::S_WRITE) && (cnt != '0));
    mreq.wr_addr = (state == skyrp_pkg::S_OPEN) ? '0 : addr;
    mreq.wr_data = (state == skyrp_pkg::S_OPEN) ? skyrp_pkg::hgt_t'(1) : ynew;
    mreq.rd_en   = (state == skyrp_pkg::S_SCAN) && (cnt != '0);
    mreq.rd_addr = addr;
  end

  // cursor step and span start
  always_comb begin
    cursor_next   = cursor;
    reversed_next = reversed;
    x_next        = x_q;
    start_scan    = 1'b0;
    unique case (state)
      skyrp_pkg::S_CUR: begin
        if (reversed) begin
          start_scan = 1'b1;
          if (alu_flag) begin          // ran past the left edge
            reversed_next = 1'b0;
            x_next        = '0;
            cursor_next   = skyrp_pkg::col_t'(w_q);
          end else begin
            x_next      = skyrp_pkg::col_t'(alu_res);
            cursor_next = skyrp_pkg::col_t'(alu_res);
          end
        end else if (over_edge) begin
          reversed_next = 1'b1;        // span placed flush right next cycle
        end else begin
          start_scan  = 1'b1;
          x_next      = cursor;
          cursor_next = skyrp_pkg::col_t'(alu_res);
        end
      end
      skyrp_pkg::S_CUR_REV: begin
        start_scan  = 1'b1;
        x_next      = skyrp_pkg::col_t'(alu_res);
        cursor_next = skyrp_pkg::col_t'(alu_res);
      end
      default: begin
        start_scan = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= skyrp_pkg::S_IDLE;
      opened    <= 1'b0;
      cur_page  <= '0;
      cursor    <= '0;
      reversed  <= 1'b0;
      pend      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (state == skyrp_pkg::S_RESULT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready)                                 out_valid <= 1'b0;

      if (state == skyrp_pkg::S_OPEN) begin
        opened   <= 1'b1;
        reversed <= 1'b0;
        cursor   <= opened ? '0 : skyrp_pkg::col_t'(1);   // first page reserves column 0
      end else begin
        cursor   <= cursor_next;
        reversed <= reversed_next;
      end

      if (start_scan) begin
        cnt  <= skyrp_pkg::col_t'(w_q);
        pend <= 1'b0;
      end else if (state == skyrp_pkg::S_SCAN) begin
        pend <= (cnt != '0);
        if (cnt != '0) cnt <= cnt - 1'b1;
      end else if (state == skyrp_pkg::S_FIT) begin
        cnt <= skyrp_pkg::col_t'(w_q);
      end else if (state == skyrp_pkg::S_WRITE) begin
        if (cnt != '0) cnt <= cnt - 1'b1;
        else           cur_page <= try_page;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      skyrp_pkg::S_IDLE: begin
        if (in_valid) begin
          w_q <= block_width;
          h_q <= block_height;
        end
      end
      skyrp_pkg::S_CHECK: begin
        try_page <= cur_page;
        code     <= skyrp_pkg::ST_TOO_LARGE;
      end
      skyrp_pkg::S_CUR, skyrp_pkg::S_CUR_REV: begin
        x_q <= x_next;
        if (start_scan) begin
          addr <= x_next[skyrp_pkg::ADDR_W-1:0];
          y_q  <= '0;
        end
      end
      skyrp_pkg::S_SCAN: begin
        if (mreq.rd_en) addr <= addr + 1'b1;
        if (pend && alu_flag) y_q <= rd_data;
      end
      skyrp_pkg::S_FIT: begin
        addr <= x_q[skyrp_pkg::ADDR_W-1:0];
        ynew <= skyrp_pkg::hgt_t'(alu_res);
        if (fit_fail) begin
          if (last_page) code <= skyrp_pkg::ST_FULL;
          else           try_page <= try_page + 1'b1;
        end
      end
      skyrp_pkg::S_WRITE: begin
        if (cnt != '0) addr <= addr + 1'b1;
        else           code <= skyrp_pkg::ST_OK;
      end
      skyrp_pkg::S_RESULT: begin
        if (!out_valid || out_ready) begin
          status <= code;
          if (code == skyrp_pkg::ST_OK) begin
            page_index <= skyrp_pkg::page_idx_t'(try_page);
            x_pos      <= skyrp_pkg::xpos_t'(x_q);
            y_pos      <= skyrp_pkg::ypos_t'(y_q);
          end else begin
            page_index <= '0;
            x_pos      <= '0;
            y_pos      <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block took an item while busy");

  a_reject_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == skyrp_pkg::ST_TOO_LARGE) |->
      (page_index == '0 && x_pos == '0 && y_pos == '0))
    else $error("oversized item reports a placement");

  a_cursor_in_page: assert property (@(posedge clk) disable iff (rst)
    cursor <= skyrp_pkg::col_t'(skyrp_pkg::PAGE_WIDTH))
    else $error("sweep cursor beyond page edge");

  a_write_height_fits: assert property (@(posedge clk) disable iff (rst)
    (state == skyrp_pkg::S_WRITE) |-> (ynew <= skyrp_pkg::hgt_t'(skyrp_pkg::PAGE_HEIGHT)))
    else $error("column raised beyond page height");

endmodule
